/* rtl/core/pfra_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfra_pkg
// Shared constants, codes and controller/datapath interface types for the
// pulse flow rate averager.
// ----------------------------------------------------------------------------
package pfra_pkg;

   // sample ring
   localparam int SAMPLE_DEPTH = 20;
   localparam int SLOT_W       = $clog2(SAMPLE_DEPTH);
   localparam int CNT_W        = $clog2(SAMPLE_DEPTH + 1);

   // field widths
   localparam int PULSE_W  = 16;
   localparam int MS_W     = 16;
   localparam int CAL_W    = 16;
   localparam int RATE_W   = 24;
   localparam int LIMIT_W  = 8;
   localparam int IDLE_W   = 9;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 24;

   // arithmetic widths
   localparam int SCALED_W   = PULSE_W + CAL_W;
   localparam int MUL_B_W    = 18;
   localparam int PROD_W     = SCALED_W + MUL_B_W;
   localparam int FRAC_SHIFT = 12;
   localparam int DIVD_W     = PROD_W - FRAC_SHIFT;
   localparam int SUM_W      = RATE_W + CNT_W;
   localparam int STEP_W     = $clog2(DIVD_W + 1);

   localparam logic [RATE_W-1:0]  MAX_RATE = '1;
   // 60 s * 1000 ms * 0.264172 gal * 256 / 30 pulses per liter, rounded
   localparam logic [MUL_B_W-1:0] RATE_NUM = 18'd135256;
   // 0.264172 gal * 65536 / 30 pulses per liter, rounded
   localparam logic [MUL_B_W-1:0] VOL_NUM  = 18'd577;

   // register reset values
   localparam logic [CAL_W-1:0]   CAL_FACTOR_RST  = 16'd4096;
   localparam logic [PULSE_W-1:0] MAX_PULSES_RST  = 16'd100;
   localparam logic [MS_W-1:0]    MAX_INTERVAL_RST = 16'd5000;
   localparam logic [RATE_W-1:0]  MIN_RATE_RST    = 24'd512;
   localparam logic [LIMIT_W-1:0] IDLE_LIMIT_RST  = 8'd60;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_CAL_FACTOR      = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_PULSES      = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_INTERVAL_MS = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_RATE        = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_IDLE_LIMIT      = 3'd4;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DECIDE,
      ST_MUL_SCALE,
      ST_MUL_RATE,
      ST_MUL_VOL,
      ST_DIV_RATE,
      ST_RATE_CHK,
      ST_RING_WR,
      ST_SUM,
      ST_AVG_START,
      ST_DIV_AVG,
      ST_DONE
   } pfra_state_type;

   typedef enum logic [1:0] {
      MSEL_SCALE,
      MSEL_RATE,
      MSEL_VOL
   } mul_sel_type;

   typedef struct packed {
      logic        load;
      logic        mul_en;
      mul_sel_type mul_sel;
      logic        div_start;
      logic        div_avg;
      logic        take_rate;
      logic        ring_write;
      logic        sum_step;
      logic        take_avg;
      logic        out_load;
   } pfra_cmd_type;

   typedef struct packed {
      logic report_ok;
      logic rate_above;
      logic sum_last;
      logic div_done;
      logic out_free;
   } pfra_status_type;

endpackage

/* rtl/core/pfra_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfra_div
// Restoring divider, one quotient bit per cycle, shared by the rate and the
// average computations.
// ----------------------------------------------------------------------------
module pfra_div
   import pfra_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic              short_run,
   input  logic [DIVD_W-1:0] dividend,
   input  logic [MS_W-1:0]   divisor,
   output logic              done,
   output logic [DIVD_W-1:0] quotient
);

   logic [DIVD_W-1:0] quo_ff;
   logic [MS_W-1:0]   rem_ff;
   logic [MS_W-1:0]   dvs_ff;
   logic [STEP_W-1:0] cnt_ff;
   logic              busy_ff;
   logic              done_ff;

   logic [MS_W:0]     trial;
   logic              fits;
   logic [MS_W-1:0]   rem_in;

   always_comb begin
      trial  = {rem_ff, quo_ff[DIVD_W-1]};
      fits   = trial >= {1'b0, dvs_ff};
      rem_in = fits ? MS_W'(trial - {1'b0, dvs_ff}) : trial[MS_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         done_ff <= 1'b0;
         // the average dividend is left aligned, so fewer steps suffice
         cnt_ff  <= short_run ? STEP_W'(SUM_W) : STEP_W'(DIVD_W);
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff - 1'b1;
         if (cnt_ff == STEP_W'(1)) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end else begin
         done_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= dividend;
         rem_ff <= '0;
         dvs_ff <= divisor;
      end else if (busy_ff) begin
         quo_ff <= {quo_ff[DIVD_W-2:0], fits};
         rem_ff <= rem_in;
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

/* rtl/core/pfra_dp.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfra_dp
// Datapath: configuration registers, idle tracking, shared multiplier,
// divider, sample ring with its sum sweep, and the result register.
// ----------------------------------------------------------------------------
module pfra_dp
   import pfra_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  pfra_cmd_type          cmd,
   output pfra_status_type       status,
   input  logic                  req_new_data,
   input  logic [PULSE_W-1:0]    req_pulse_count,
   input  logic [MS_W-1:0]       req_interval_ms,
   input  logic                  csr_valid,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [RATE_W-1:0]     rsp_interval_gallons,
   output logic                  rsp_interval_written,
   output logic [RATE_W-1:0]     rsp_avg_rate,
   output logic                  rsp_avg_updated,
   output logic                  rsp_store_cleared,
   output logic                  rsp_rate_saturated
);

   // configuration
   logic [CAL_W-1:0]   cal_factor_ff;
   logic [PULSE_W-1:0] max_pulses_ff;
   logic [MS_W-1:0]    max_interval_ff;
   logic [RATE_W-1:0]  min_rate_ff;
   logic [LIMIT_W-1:0] idle_limit_ff;

   // per report
   logic [PULSE_W-1:0]  pulses_ff;
   logic [MS_W-1:0]     ms_ff;
   logic                ok_ff;
   logic                cleared_ff;
   logic [SCALED_W-1:0] scaled_ff;
   logic [DIVD_W-1:0]   rate_num_ff;
   logic [RATE_W-1:0]   gallons_ff;
   logic [RATE_W-1:0]   rate_ff;
   logic                sat_ff;
   logic                updated_ff;

   // persistent state
   logic [IDLE_W-1:0]       idle_ff;
   logic [RATE_W-1:0]       avg_ff;
   logic [SAMPLE_DEPTH-1:0] slot_valid_ff;
   logic [SLOT_W-1:0]       write_slot_ff;
   logic [RATE_W-1:0]       samples_ff [SAMPLE_DEPTH];

   // sum sweep
   logic [SLOT_W-1:0] sweep_ff;
   logic [SUM_W-1:0]  sum_ff;
   logic [CNT_W-1:0]  cnt_ff;

   // result register
   logic              rsp_valid_ff;
   logic [RATE_W-1:0] rsp_gallons_ff;
   logic              rsp_written_ff;
   logic [RATE_W-1:0] rsp_avg_ff;
   logic              rsp_updated_ff;
   logic              rsp_cleared_ff;
   logic              rsp_sat_ff;

   // combinational
   logic [IDLE_W-1:0]   idle_inc;
   logic                timeout;
   logic                report_ok_in;
   logic [SCALED_W-1:0] mul_a;
   logic [MUL_B_W-1:0]  mul_b;
   logic [PROD_W-1:0]   product;
   logic [DIVD_W-1:0]   prod_shr;
   logic [DIVD_W-1:0]   div_dividend;
   logic [MS_W-1:0]     div_divisor;
   logic                div_done;
   logic [DIVD_W-1:0]   div_quotient;

   always_comb begin
      idle_inc     = (idle_ff == '1) ? idle_ff : idle_ff + 1'b1;
      timeout      = !req_new_data && (idle_inc > {1'b0, idle_limit_ff});
      report_ok_in = req_new_data && (req_pulse_count <= max_pulses_ff)
                     && (req_interval_ms != '0) && (req_interval_ms < max_interval_ff);
   end

   // shared multiplier
   always_comb begin
      case (cmd.mul_sel)
         MSEL_SCALE: begin
            mul_a = SCALED_W'(pulses_ff);
            mul_b = MUL_B_W'(cal_factor_ff);
         end
         MSEL_RATE: begin
            mul_a = scaled_ff;
            mul_b = RATE_NUM;
         end
         MSEL_VOL: begin
            mul_a = scaled_ff;
            mul_b = VOL_NUM;
         end
         default: begin
            mul_a = scaled_ff;
            mul_b = VOL_NUM;
         end
      endcase
      product  = PROD_W'(mul_a) * PROD_W'(mul_b);
      prod_shr = product[PROD_W-1:FRAC_SHIFT];
   end

   always_comb begin
      if (cmd.div_avg) begin
         div_dividend = {sum_ff, {(DIVD_W - SUM_W){1'b0}}};
         div_divisor  = MS_W'(cnt_ff);
      end else begin
         div_dividend = rate_num_ff;
         div_divisor  = ms_ff;
      end
   end

   pfra_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.div_start),
      .short_run (cmd.div_avg),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .done      (div_done),
      .quotient  (div_quotient)
   );

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         cal_factor_ff   <= CAL_FACTOR_RST;
         max_pulses_ff   <= MAX_PULSES_RST;
         max_interval_ff <= MAX_INTERVAL_RST;
         min_rate_ff     <= MIN_RATE_RST;
         idle_limit_ff   <= IDLE_LIMIT_RST;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_CAL_FACTOR:      cal_factor_ff   <= csr_data[CAL_W-1:0];
            CSR_MAX_PULSES:      max_pulses_ff   <= csr_data[PULSE_W-1:0];
            CSR_MAX_INTERVAL_MS: max_interval_ff <= csr_data[MS_W-1:0];
            CSR_MIN_RATE:        min_rate_ff     <= csr_data[RATE_W-1:0];
            CSR_IDLE_LIMIT:      idle_limit_ff   <= csr_data[LIMIT_W-1:0];
            default: ;
         endcase
      end
   end

   // state that reset clears
   always_ff @(posedge clock) begin
      if (reset) begin
         idle_ff       <= '0;
         avg_ff        <= '0;
         slot_valid_ff <= '0;
         write_slot_ff <= '0;
      end else begin
         if (cmd.load) begin
            if (req_new_data || timeout) begin
               idle_ff <= '0;
            end else begin
               idle_ff <= idle_inc;
            end
            if (timeout) begin
               slot_valid_ff <= '0;
            end
         end
         if (cmd.ring_write) begin
            slot_valid_ff[write_slot_ff] <= 1'b1;
            if (write_slot_ff == SLOT_W'(SAMPLE_DEPTH - 1)) begin
               write_slot_ff <= '0;
            end else begin
               write_slot_ff <= write_slot_ff + 1'b1;
            end
         end
         if (cmd.take_avg) begin
            avg_ff <= div_quotient[RATE_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.ring_write) begin
         samples_ff[write_slot_ff] <= rate_ff;
      end
   end

   // per-report working registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         pulses_ff  <= req_pulse_count;
         ms_ff      <= req_interval_ms;
         ok_ff      <= report_ok_in && !timeout;
         cleared_ff <= timeout;
         gallons_ff <= '0;
         sat_ff     <= 1'b0;
         updated_ff <= 1'b0;
      end
      if (cmd.mul_en) begin
         case (cmd.mul_sel)
            MSEL_SCALE: scaled_ff   <= product[SCALED_W-1:0];
            MSEL_RATE:  rate_num_ff <= prod_shr;
            MSEL_VOL:   gallons_ff  <= (|prod_shr[DIVD_W-1:RATE_W]) ? MAX_RATE
                                                                    : prod_shr[RATE_W-1:0];
            default: ;
         endcase
      end
      if (cmd.take_rate) begin
         sat_ff  <= |div_quotient[DIVD_W-1:RATE_W];
         rate_ff <= (|div_quotient[DIVD_W-1:RATE_W]) ? MAX_RATE : div_quotient[RATE_W-1:0];
      end
      if (cmd.ring_write) begin
         sweep_ff <= '0;
         sum_ff   <= '0;
         cnt_ff   <= '0;
      end
      if (cmd.sum_step) begin
         sweep_ff <= sweep_ff + 1'b1;
         if (slot_valid_ff[sweep_ff]) begin
            sum_ff <= sum_ff + SUM_W'(samples_ff[sweep_ff]);
            cnt_ff <= cnt_ff + 1'b1;
         end
      end
      if (cmd.take_avg) begin
         updated_ff <= 1'b1;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_gallons_ff <= gallons_ff;
         rsp_written_ff <= !cleared_ff;
         rsp_avg_ff     <= avg_ff;
         rsp_updated_ff <= updated_ff;
         rsp_cleared_ff <= cleared_ff;
         rsp_sat_ff     <= sat_ff;
      end
   end

   always_comb begin
      status.report_ok  = ok_ff;
      status.rate_above = rate_ff > min_rate_ff;
      status.sum_last   = sweep_ff == SLOT_W'(SAMPLE_DEPTH - 1);
      status.div_done   = div_done;
      status.out_free   = !rsp_valid_ff || rsp_ready;
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_interval_gallons = rsp_gallons_ff;
   assign rsp_interval_written = rsp_written_ff;
   assign rsp_avg_rate         = rsp_avg_ff;
   assign rsp_avg_updated      = rsp_updated_ff;
   assign rsp_store_cleared    = rsp_cleared_ff;
   assign rsp_rate_saturated   = rsp_sat_ff;

endmodule

/* rtl/core/pfra_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfra_ctrl
// Controller: sequences multiply, divide, ring update, sum sweep and result
// hand-off for one report at a time.
// ----------------------------------------------------------------------------
module pfra_ctrl
   import pfra_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  pfra_status_type status,
   output pfra_cmd_type    cmd
);

   pfra_state_type state_ff;
   pfra_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:      if (req_valid) state_in = ST_DECIDE;
         ST_DECIDE:    state_in = status.report_ok ? ST_MUL_SCALE : ST_DONE;
         ST_MUL_SCALE: state_in = ST_MUL_RATE;
         ST_MUL_RATE:  state_in = ST_MUL_VOL;
         ST_MUL_VOL:   state_in = ST_DIV_RATE;
         ST_DIV_RATE:  if (status.div_done) state_in = ST_RATE_CHK;
         ST_RATE_CHK:  state_in = status.rate_above ? ST_RING_WR : ST_DONE;
         ST_RING_WR:   state_in = ST_SUM;
         ST_SUM:       if (status.sum_last) state_in = ST_AVG_START;
         ST_AVG_START: state_in = ST_DIV_AVG;
         ST_DIV_AVG:   if (status.div_done) state_in = ST_DONE;
         ST_DONE:      if (status.out_free) state_in = ST_IDLE;
         default:      state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd         = '0;
      cmd.mul_sel = MSEL_SCALE;
      req_ready   = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         ST_MUL_SCALE: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MSEL_SCALE;
         end
         ST_MUL_RATE: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MSEL_RATE;
         end
         ST_MUL_VOL: begin
            // rate numerator is ready, so the division starts here too
            cmd.mul_en    = 1'b1;
            cmd.mul_sel   = MSEL_VOL;
            cmd.div_start = 1'b1;
         end
         ST_DIV_RATE:  cmd.take_rate = status.div_done;
         ST_RING_WR:   cmd.ring_write = 1'b1;
         ST_SUM:       cmd.sum_step = 1'b1;
         ST_AVG_START: begin
            cmd.div_start = 1'b1;
            cmd.div_avg   = 1'b1;
         end
         ST_DIV_AVG: begin
            cmd.div_avg  = 1'b1;
            cmd.take_avg = status.div_done;
         end
         ST_DONE:      cmd.out_load = status.out_free;
         default: ;
      endcase
   end

endmodule

/* rtl/core/pulse_flow_rate_averager_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pulse_flow_rate_averager_core
// Interval flow reports in, per-interval volume and running average rate out.
// ----------------------------------------------------------------------------
//  channel | ports                                  | transfer when
//  --------+----------------------------------------+----------------------
//  req     | new_data, pulse_count, interval_ms     | req_valid & req_ready
//  rsp     | interval_gallons .. rate_saturated     | rsp_valid & rsp_ready
//  csr     | index, data (write only)               | csr_valid & csr_ready
//
//  one report at a time; idle, timeout or invalid reports go straight to
//  the result; a valid report runs the rate division through the shared
//  divider, and one that updates the average also runs the 20-slot sum
//  sweep and the average division, which works on the 29-bit sum only
//  reset is synchronous and needs no clearing pass; csr is always ready
//  the result register lets the next report be taken while rsp is stalled
// ----------------------------------------------------------------------------
module pulse_flow_rate_averager_core
   import pfra_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic                  req_new_data,
   input  logic [PULSE_W-1:0]    req_pulse_count,
   input  logic [MS_W-1:0]       req_interval_ms,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [RATE_W-1:0]     rsp_interval_gallons,
   output logic                  rsp_interval_written,
   output logic [RATE_W-1:0]     rsp_avg_rate,
   output logic                  rsp_avg_updated,
   output logic                  rsp_store_cleared,
   output logic                  rsp_rate_saturated,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   pfra_cmd_type    cmd;
   pfra_status_type status;

   assign csr_ready = 1'b1;

   pfra_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   pfra_dp u_dp (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .status               (status),
      .req_new_data         (req_new_data),
      .req_pulse_count      (req_pulse_count),
      .req_interval_ms      (req_interval_ms),
      .csr_valid            (csr_valid),
      .csr_index            (csr_index),
      .csr_data             (csr_data),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_interval_gallons (rsp_interval_gallons),
      .rsp_interval_written (rsp_interval_written),
      .rsp_avg_rate         (rsp_avg_rate),
      .rsp_avg_updated      (rsp_avg_updated),
      .rsp_store_cleared    (rsp_store_cleared),
      .rsp_rate_saturated   (rsp_rate_saturated)
   );

`ifndef ASSERT_OFF
   // one report in flight: after a transfer the input side closes
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("report accepted while another is in flight");

   // a timeout result carries no volume, no clip and no average update
   a_timeout_result: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_store_cleared) |-> (rsp_interval_gallons == '0
         && !rsp_interval_written && !rsp_avg_updated && !rsp_rate_saturated))
      else $error("timeout result carries data");

   // only the timeout suppresses the written flag
   a_written_flag: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_interval_written) |-> rsp_store_cleared)
      else $error("interval not written without timeout");

   // an average update needs a nonzero sample, hence a nonzero average
   a_update_nonzero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_avg_updated) |-> (rsp_avg_rate != '0))
      else $error("average updated to zero");
`endif

endmodule
